// ===== src/ptl_pkg.sv =====
// Package for the property text lexer: lexer states, character classes,
// token kind codes, character constants and the beat structures.
// No dependencies.
package ptl_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int LINE_OUT_BITS = 16;
    localparam int KIND_BITS     = 4;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_VTAB   = 8'h0B;

    localparam logic [KIND_BITS-1:0] KIND_WORD    = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_INTEGER = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_DECIMAL = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_STRING  = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_PATH    = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_COLON   = 4'd11;
    localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd12;
    localparam logic [KIND_BITS-1:0] KIND_EQUALS  = 4'd13;
    localparam logic [KIND_BITS-1:0] KIND_SEMI    = 4'd14;
    localparam logic [KIND_BITS-1:0] KIND_NONE    = 4'd0;

    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_SYM   = 3'd1,
        ST_WORD  = 3'd2,
        ST_STR   = 3'd3,
        ST_INT   = 3'd4,
        ST_DEC   = 3'd5,
        ST_PATH  = 3'd6
    } lex_state_t;

    typedef enum logic [3:0] {
        CC_QUOTE,
        CC_DIGIT,
        CC_DOT,
        CC_SLASH,
        CC_ALPHA,
        CC_SPACE,
        CC_NEWLINE,
        CC_SYMBOL,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t          cls;
        logic [KIND_BITS-1:0] sym;
        logic [7:0]           byte_val;
    } char_info_t;

    typedef struct packed {
        logic                     token_done;
        logic [KIND_BITS-1:0]     token_kind;
        logic                     append_valid;
        logic [7:0]               byte_out;
        logic                     bad_char;
        logic [LINE_OUT_BITS-1:0] line_number;
        logic                     text_finished;
    } lex_result_t;

    function automatic logic [KIND_BITS-1:0] symbol_code(input logic [7:0] c);
        logic [KIND_BITS-1:0] code;
        case (c)
            8'h28: code = KIND_LPAREN;
            8'h29: code = KIND_RPAREN;
            8'h5B: code = KIND_LBRACK;
            8'h5D: code = KIND_RBRACK;
            8'h7B: code = KIND_LBRACE;
            8'h7D: code = KIND_RBRACE;
            8'h3A: code = KIND_COLON;
            8'h2C: code = KIND_COMMA;
            8'h3D: code = KIND_EQUALS;
            8'h3B: code = KIND_SEMI;
            default: code = KIND_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== src/ptl_char_class.sv =====
// Character classifier for the property text lexer.
// Maps the dollar sign onto the hash sign and sorts each byte into a class.
// Depends on ptl_pkg.
module ptl_char_class
    import ptl_pkg::*;
(
    input  logic [7:0] text_byte,
    output char_info_t info
);

    logic [7:0]           c;
    logic [KIND_BITS-1:0] sym;

    assign c   = (text_byte == CHAR_DOLLAR) ? CHAR_HASH : text_byte;
    assign sym = symbol_code(c);

    always_comb begin
        info.byte_val = c;
        info.sym      = sym;
        if (c == 8'h22) begin
            info.cls = CC_QUOTE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            info.cls = CC_DIGIT;
        end else if (c == 8'h2E) begin
            info.cls = CC_DOT;
        end else if (c == 8'h2F || c == 8'h5C) begin
            info.cls = CC_SLASH;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
                     || c == 8'h5F) begin
            info.cls = CC_ALPHA;
        end else if (c == 8'h0A) begin
            info.cls = CC_NEWLINE;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == CHAR_VTAB) begin
            info.cls = CC_SPACE;
        end else if (sym != KIND_NONE) begin
            info.cls = CC_SYMBOL;
        end else begin
            info.cls = CC_OTHER;
        end
    end

endmodule

// ===== src/ptl_lex_core.sv =====
// Lexer state machine: state, pending symbol, token flag, line counter and
// failure flag, with the result of the beat now being consumed.
// Depends on ptl_pkg.
module ptl_lex_core
    import ptl_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        end_of_text,
    input  char_info_t  info,
    output lex_result_t result
);

    lex_state_t           state_reg, state_next;
    logic [KIND_BITS-1:0] sym_reg, sym_next;
    logic                 nonempty_reg, nonempty_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 failed_reg, failed_next;

    logic                 pending;
    logic [KIND_BITS-1:0] state_kind;
    logic                 term;
    logic                 discard;

    assign pending = (state_reg != ST_START) && (nonempty_reg || state_reg == ST_STR);

    always_comb begin
        case (state_reg)
            ST_WORD: state_kind = KIND_WORD;
            ST_INT:  state_kind = KIND_INTEGER;
            ST_DEC:  state_kind = KIND_DECIMAL;
            ST_STR:  state_kind = KIND_STRING;
            ST_PATH: state_kind = KIND_PATH;
            default: state_kind = sym_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_START;
            sym_reg      <= KIND_NONE;
            nonempty_reg <= 1'b0;
            line_reg     <= LINE_BITS'(1);
            failed_reg   <= 1'b0;
        end else if (advance) begin
            state_reg    <= state_next;
            sym_reg      <= sym_next;
            nonempty_reg <= nonempty_next;
            line_reg     <= line_next;
            failed_reg   <= failed_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        sym_next      = sym_reg;
        nonempty_next = nonempty_reg;
        line_next     = line_reg;
        failed_next   = failed_reg;
        term          = 1'b0;
        discard       = 1'b0;

        result               = '0;
        result.byte_out      = info.byte_val;
        result.line_number   = LINE_OUT_BITS'(line_reg);

        if (end_of_text) begin
            result.token_done    = !failed_reg && state_reg != ST_STR && pending;
            result.token_kind    = result.token_done ? state_kind : KIND_NONE;
            result.byte_out      = 8'h00;
            result.bad_char      = failed_reg;
            result.text_finished = 1'b1;
            state_next           = ST_START;
            sym_next             = KIND_NONE;
            nonempty_next        = 1'b0;
            line_next            = LINE_BITS'(1);
            failed_next          = 1'b0;
        end else if (failed_reg) begin
            result.bad_char = 1'b1;
        end else if ((info.cls == CC_SPACE || info.cls == CC_NEWLINE)
                     && state_reg != ST_STR) begin
            if (info.cls == CC_NEWLINE && line_reg != '1) begin
                line_next = line_reg + LINE_BITS'(1);
            end
            result.line_number = LINE_OUT_BITS'(line_next);
        end else if (info.cls == CC_OTHER && state_reg != ST_STR) begin
            failed_next     = 1'b1;
            result.bad_char = 1'b1;
        end else begin
            if (info.cls == CC_QUOTE) begin
                state_next = (state_reg == ST_STR) ? ST_START : ST_STR;
                term       = 1'b1;
                discard    = 1'b1;
            end else if (state_reg == ST_STR) begin
                state_next = ST_STR;
            end else begin
                case (info.cls)
                    CC_DIGIT: begin
                        if (state_reg != ST_WORD && state_reg != ST_INT
                            && state_reg != ST_DEC) begin
                            state_next = ST_INT;
                            term       = 1'b1;
                        end
                    end
                    CC_DOT: begin
                        if (state_reg == ST_PATH || state_reg == ST_START) begin
                            state_next = ST_PATH;
                        end else if (state_reg == ST_INT) begin
                            state_next = ST_DEC;
                        end else begin
                            state_next = ST_PATH;
                            term       = 1'b1;
                        end
                    end
                    CC_SLASH: begin
                        state_next = ST_PATH;
                        term       = !(state_reg == ST_PATH || state_reg == ST_START);
                    end
                    CC_ALPHA: begin
                        if (state_reg == ST_PATH) begin
                            state_next = ST_PATH;
                        end else if (state_reg == ST_INT || state_reg == ST_WORD
                                     || state_reg == ST_START) begin
                            state_next = ST_WORD;
                        end else begin
                            state_next = ST_WORD;
                            term       = 1'b1;
                        end
                    end
                    CC_SYMBOL: begin
                        state_next = ST_SYM;
                        term       = 1'b1;
                        sym_next   = info.sym;
                    end
                    default: begin
                        state_next = state_reg;
                    end
                endcase
            end

            if (term) begin
                result.token_done = pending;
                result.token_kind = pending ? state_kind : KIND_NONE;
                nonempty_next     = 1'b0;
            end
            if (!discard) begin
                nonempty_next       = 1'b1;
                result.append_valid = 1'b1;
            end
        end
    end

endmodule

// ===== src/property_text_lexer_unit.sv =====
// Top level of the property text lexer: input beat register, classifier,
// lexer core and result register with streaming handshakes.
// Depends on ptl_pkg, ptl_char_class and ptl_lex_core.

// One text byte or end marker per beat, one result beat per input beat. A
// beat sits in the input register, where the classifier and the lexer state
// machine work on it, until the result register can take it, and its result
// is then registered there; a new beat is taken every cycle while the result
// side keeps up. s_tlast marks the end marker, which flushes the pending token
// (unless the text failed or a string is open) and returns the lexer to its
// start state; m_tlast echoes it. A bad character raises bad_char, which stays
// up until the end marker; drop the text's tokens then.
module property_text_lexer_unit
    import ptl_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] token_done, [4:1] token_kind, [5] append_valid,
                                   // [13:6] byte_out, [14] bad_char, [30:15] line_number
    output logic        m_tlast    // text_finished
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        out_valid_reg, out_valid_next;
    lex_result_t out_reg;

    logic        advance;
    char_info_t  info;
    lex_result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tvalid || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    ptl_char_class u_char_class (
        .text_byte (in_byte_reg),
        .info      (info)
    );

    ptl_lex_core #(
        .LINE_BITS (LINE_BITS)
    ) u_lex_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .end_of_text (in_end_reg),
        .info        (info),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.text_finished;
    assign m_tdata  = {1'b0, out_reg.line_number, out_reg.bad_char, out_reg.byte_out,
                       out_reg.append_valid, out_reg.token_kind, out_reg.token_done};

`ifndef SYNTH
    a_done_not_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.token_done) |-> !out_reg.bad_char)
        else $error("token ended on a failed text");

    a_kind_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_reg.token_done) |-> (out_reg.token_kind == KIND_NONE))
        else $error("token kind set without a token end");

    a_finish_no_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.text_finished) |-> !out_reg.append_valid)
        else $error("end marker appended to a token");

    a_bad_no_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.bad_char) |-> (!out_reg.append_valid && !out_reg.token_done))
        else $error("failed text still building tokens");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("consumed beat lost before the result register");
`endif

endmodule
